/* hdl/sbf_pkg.sv */
// Package for the spring beam force block: request and result structs,
// status codes and fixed-point constants.
// No dependencies.
`default_nettype none

package sbf_pkg;

  typedef enum logic [1:0] {
    ST_ACTIVE  = 2'd0,
    ST_MISSING = 2'd1,
    ST_BROKEN  = 2'd2,
    ST_GONE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_STIFFNESS  = 2'd0,
    REG_RESISTANCE = 2'd1,
    REG_BEAM_MASS  = 2'd2,
    REG_BREAKABLE  = 2'd3
  } reg_idx_t;

  localparam logic [46:0] MAX47     = 47'h7FFF_FFFF_FFFF;
  localparam logic [9:0]  GRAV_K    = 10'd980;
  localparam logic [31:0] STIFF_RST = 32'd65536;
  localparam logic [15:0] MASS_RST  = 16'd256;

  typedef struct packed {
    logic               pins_present;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [47:0] start_force_x;
    logic signed [47:0] start_force_y;
    logic signed [47:0] start_force_z;
    logic signed [47:0] end_force_x;
    logic signed [47:0] end_force_y;
    logic signed [47:0] end_force_z;
    logic signed [47:0] tension_out;
    logic        [32:0] length_out;
  } out_t;

endpackage

`default_nettype wire

/* hdl/spring_beam_force_with_break.sv */
// Spring beam force element with breaking, top level.
// Depends on sbf_pkg.
//
// Usage: a request carries both pin positions and a pins-present flag; each
// request yields exactly one result. Both channels are valid/ready.
// A live request walks a small sequencer around one shared 32x32 multiplier,
// a bit-serial square root and a bit-serial divider:
//   squares, root, tension and break check, then per axis divider setup,
//   divide and force products, then force folding and hand-off. A request on
//   a removed beam, or one with a missing pin, goes straight to hand-off.
// in_ready is high only while the sequencer is idle, so one request is in
// flight at a time. Finished results sit in an output register; a new request
// is taken while that result still waits, and the sequencer holds its next
// result until the output register is free. Reset: configuration returns to
// its defaults, the rest length is unlatched and the beam is alive; the
// output register is emptied. The user must write configuration through
// cfg_wen/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none

module spring_beam_force_with_break (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sbf_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sbf_pkg::out_t       out_data,
  input  wire logic           cfg_wen,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [46:0]    cfg_wdata
);

  localparam int RES_W = $bits(sbf_pkg::out_t);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SQ    = 10'b00_0000_0010,
    S_SQRT  = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_TEN   = 10'b00_0001_0000,
    S_BRK   = 10'b00_0010_0000,
    S_DINIT = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_FMUL  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [31:0] stiffness;
  logic [46:0] resistance;
  logic [15:0] beam_mass;
  logic        breakable;

  // beam state
  logic [32:0] rest_length;
  logic        rest_latched;
  logic        removed;

  // datapath
  logic [5:0]         cnt;
  logic [1:0]         k;
  logic signed [32:0] d [3];
  logic signed [48:0] u [3];
  logic [65:0]        acc;
  logic [35:0]        rem;
  logic [32:0]        len;
  logic [63:0]        prod;
  logic [40:0]        lo_prod;
  logic               m_top;
  logic               str_neg;
  logic signed [47:0] tension;
  logic [47:0]        mt;
  logic [32:0]        drem;
  logic [16:0]        quo;
  logic               force_pending;
  sbf_pkg::out_t      res;

  // combinational
  logic [1:0]         sq_idx;
  logic [1:0]         ax;
  logic [31:0]        abs_ax;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [37:0]        rem_sh;
  logic [37:0]        trial;
  logic               sq_ge;
  logic [33:0]        drem_sh;
  logic               div_ge;
  logic [32:0]        rest_eff;
  logic signed [33:0] stretch;
  logic [32:0]        m_abs;
  logic [64:0]        p_full;
  logic [48:0]        p_mag;
  logic signed [47:0] tension_c;
  logic [64:0]        f_sum;
  logic [47:0]        f_mag;
  logic signed [48:0] u_c;
  logic [25:0]        grav_mag;
  logic signed [49:0] grav;

  function automatic logic signed [47:0] half_sat(input logic signed [49:0] s);
    logic signed [49:0] h;
    h = (s + $signed({49'd0, s[49]})) >>> 1;
    if (h > $signed({3'b000, sbf_pkg::MAX47}))
      half_sat = $signed({1'b0, sbf_pkg::MAX47});
    else if (h < -$signed({3'b000, sbf_pkg::MAX47}) - 50'sd1)
      half_sat = $signed({1'b1, 47'd0});
    else
      half_sat = h[47:0];
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? -v : v;
    mag33 = t[31:0];
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    sq_idx = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    ax     = (state == S_SQ) ? sq_idx : k;
    abs_ax = mag33(d[ax]);

    rest_eff = rest_latched ? rest_length : len;
    stretch  = $signed({1'b0, len}) - $signed({1'b0, rest_eff});
    m_abs    = stretch[33] ? 33'(-stretch) : stretch[32:0];

    case (state)
      S_SQ: begin
        mul_a = abs_ax;
        mul_b = abs_ax;
      end
      S_MUL: begin
        mul_a = m_abs[31:0];
        mul_b = stiffness;
      end
      S_FMUL: begin
        mul_a = (cnt == 6'd0) ? {8'd0, mt[23:0]} : {8'd0, mt[47:24]};
        mul_b = (len == 33'd0) ? 32'd0 : {15'd0, quo};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    mul_p = mul_a * mul_b;

    rem_sh = {rem, acc[65:64]};
    trial  = {3'd0, len, 2'b01};
    sq_ge  = (rem_sh >= trial);

    drem_sh = {drem, (cnt == 6'd0) ? abs_ax[0] : 1'b0};
    div_ge  = (drem_sh >= {1'b0, len});

    p_full = {1'b0, prod} + (m_top ? {1'b0, stiffness, 32'd0} : 65'd0);
    p_mag  = p_full[64:16];
    if (p_mag > {2'b00, sbf_pkg::MAX47})
      tension_c = str_neg ? $signed({1'b1, 47'd0}) : $signed({1'b0, sbf_pkg::MAX47});
    else
      tension_c = str_neg ? -$signed(p_mag[47:0]) : $signed(p_mag[47:0]);

    f_sum = {prod[40:0], 24'd0} + {24'd0, lo_prod};
    f_mag = f_sum[63:16];
    u_c   = (d[k][32] ^ tension[47]) ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});

    grav_mag = beam_mass * sbf_pkg::GRAV_K;
    grav     = -$signed({24'd0, grav_mag});
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness  <= sbf_pkg::STIFF_RST;
      resistance <= sbf_pkg::MAX47;
      beam_mass  <= sbf_pkg::MASS_RST;
      breakable  <= 1'b1;
    end else if (cfg_wen) begin
      case (sbf_pkg::reg_idx_t'(cfg_addr))
        sbf_pkg::REG_STIFFNESS:  stiffness  <= cfg_wdata[31:0];
        sbf_pkg::REG_RESISTANCE: resistance <= cfg_wdata;
        sbf_pkg::REG_BEAM_MASS:  beam_mass  <= cfg_wdata[15:0];
        sbf_pkg::REG_BREAKABLE:  breakable  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rest_latched  <= 1'b0;
      rest_length   <= 33'd0;
      removed       <= 1'b0;
      cnt           <= 6'd0;
      k             <= 2'd0;
      force_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            d[0] <= 33'(in_data.end_x) - 33'(in_data.start_x);
            d[1] <= 33'(in_data.end_y) - 33'(in_data.start_y);
            d[2] <= 33'(in_data.end_z) - 33'(in_data.start_z);
            cnt  <= 6'd0;
            acc  <= 66'd0;
            if (removed) begin
              res   <= {sbf_pkg::ST_GONE, (RES_W - 2)'(0)};
              state <= S_DONE;
            end else if (!in_data.pins_present) begin
              removed <= 1'b1;
              res     <= {sbf_pkg::ST_MISSING, (RES_W - 2)'(0)};
              state   <= S_DONE;
            end else begin
              res   <= '0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          prod <= mul_p;
          if (cnt != 6'd0) acc <= acc + {2'd0, prod};
          if (cnt == 6'd3) begin
            cnt   <= 6'd0;
            rem   <= 36'd0;
            len   <= 33'd0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SQRT: begin
          rem <= sq_ge ? 36'(rem_sh - trial) : rem_sh[35:0];
          len <= {len[31:0], sq_ge};
          acc <= {acc[63:0], 2'b00};
          if (cnt == 6'd32) begin
            cnt   <= 6'd0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_MUL: begin
          prod    <= mul_p;
          m_top   <= m_abs[32];
          str_neg <= stretch[33];
          if (!rest_latched) begin
            rest_length  <= len;
            rest_latched <= 1'b1;
          end
          state <= S_TEN;
        end
        S_TEN: begin
          tension <= tension_c;
          state   <= S_BRK;
        end
        S_BRK: begin
          res.tension_out <= tension;
          res.length_out  <= len;
          if (breakable && (tension > $signed({1'b0, resistance}))) begin
            removed    <= 1'b1;
            res.status <= sbf_pkg::ST_BROKEN;
            state      <= S_DONE;
          end else begin
            mt    <= tension[47] ? 48'(-tension) : tension;
            k     <= 2'd0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          drem  <= {2'd0, abs_ax[31:1]};
          quo   <= 17'd0;
          cnt   <= 6'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= div_ge ? 33'(drem_sh - {1'b0, len}) : drem_sh[32:0];
          quo  <= {quo[15:0], div_ge};
          if (cnt == 6'd16) begin
            cnt   <= 6'd0;
            state <= S_FMUL;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_FMUL: begin
          if (cnt == 6'd0) begin
            prod <= mul_p;
            cnt  <= 6'd1;
          end else if (cnt == 6'd1) begin
            lo_prod <= prod[40:0];
            prod    <= mul_p;
            cnt     <= 6'd2;
          end else begin
            u[k] <= u_c;
            cnt  <= 6'd0;
            if (k == 2'd2) begin
              force_pending <= 1'b1;
              state         <= S_DONE;
            end else begin
              k     <= k + 2'd1;
              state <= S_DINIT;
            end
          end
        end
        S_DONE: begin
          // forces are folded in once, on the first cycle here
          if (force_pending) begin
            force_pending     <= 1'b0;
            res.status        <= sbf_pkg::ST_ACTIVE;
            res.start_force_x <= half_sat(50'(u[0]));
            res.start_force_y <= half_sat(50'(u[1]));
            res.start_force_z <= half_sat(50'(u[2]) + grav);
            res.end_force_x   <= half_sat(-50'(u[0]));
            res.end_force_y   <= half_sat(-50'(u[1]));
            res.end_force_z   <= half_sat(grav - 50'(u[2]));
          end else if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && !force_pending && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && !force_pending && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for spring_beam_force_with_break: random and directed pin
// requests, checked against a behavioural predictor in a scoreboard class.
// Depends on sbf_pkg and the block's RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sbf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sbf_pkg::out_t out_data;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [46:0] cfg_wdata = '0;

  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  localparam int CYCLE_LIMIT = 900000;

  spring_beam_force_with_break u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_wen(cfg_wen), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class beam_scoreboard;
    logic [31:0]   stiff;
    logic [46:0]   resist;
    logic [15:0]   mass;
    logic          brk;
    logic [32:0]   rest_len;
    bit            latched;
    bit            gone;
    int            errors = 0;
    sbf_pkg::out_t pending[$];

    task report(input string what, input logic [63:0] got,
                input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    function void clear_beam();
      stiff = sbf_pkg::STIFF_RST; resist = sbf_pkg::MAX47;
      mass = sbf_pkg::MASS_RST; brk = 1'b1;
      rest_len = '0; latched = 0; gone = 0;
    endfunction

    function void write_reg(sbf_pkg::reg_idx_t idx, logic [46:0] val);
      case (idx)
        sbf_pkg::REG_STIFFNESS:  stiff = val[31:0];
        sbf_pkg::REG_RESISTANCE: resist = val;
        sbf_pkg::REG_BEAM_MASS:  mass = val[15:0];
        sbf_pkg::REG_BREAKABLE:  brk = val[0];
        default: ;
      endcase
    endfunction

    static function logic [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    static function longint sat48(longint v);
      if (v > longint'(sbf_pkg::MAX47)) return longint'(sbf_pkg::MAX47);
      if (v < -longint'(sbf_pkg::MAX47) - 1) return -longint'(sbf_pkg::MAX47) - 1;
      return v;
    endfunction

    function void note_request(sbf_pkg::in_t r);
      sbf_pkg::out_t o;
      longint d[3], stretch, tension, grav, f, g;
      logic [65:0] sum, rem, trial;
      logic [32:0] root, len;
      logic [63:0] m, prod, mt, q;
      bit neg;
      o = '0;
      if (gone) begin
        o.status = sbf_pkg::ST_GONE; pending.push_back(o); return;
      end
      if (!r.pins_present) begin
        gone = 1; o.status = sbf_pkg::ST_MISSING; pending.push_back(o); return;
      end
      d[0] = longint'(r.end_x) - longint'(r.start_x);
      d[1] = longint'(r.end_y) - longint'(r.start_y);
      d[2] = longint'(r.end_z) - longint'(r.start_z);
      sum = '0;
      for (int i = 0; i < 3; i++) sum += 66'(mag(d[i])) * 66'(mag(d[i]));
      rem = '0; root = '0;
      for (int i = 32; i >= 0; i--) begin
        rem = (rem << 2) | 66'(sum[2*i +: 2]);
        trial = (66'(root) << 2) | 66'd1;
        if (rem >= trial) begin
          rem -= trial; root = (root << 1) | 33'd1;
        end else begin
          root = root << 1;
        end
      end
      len = root;
      if (!latched) begin
        rest_len = len; latched = 1;
      end
      stretch = longint'({31'd0, len}) - longint'({31'd0, rest_len});
      m = mag(stretch);
      prod = (m >> 16) * stiff + (((m & 64'hFFFF) * stiff) >> 16);
      if (stretch >= 0)
        tension = prod > sbf_pkg::MAX47 ? longint'(sbf_pkg::MAX47) : longint'(prod);
      else
        tension = prod > sbf_pkg::MAX47 ? -longint'(sbf_pkg::MAX47) - 1 : -longint'(prod);
      o.tension_out = tension[47:0];
      o.length_out = len;
      if (brk && tension > longint'({17'd0, resist})) begin
        gone = 1; o.status = sbf_pkg::ST_BROKEN; pending.push_back(o); return;
      end
      mt = mag(tension);
      grav = -longint'(sbf_pkg::GRAV_K) * longint'({48'd0, mass});
      for (int i = 0; i < 3; i++) begin
        q = (len != 0) ? (mag(d[i]) << 16) / len : 64'd0;
        f = longint'((mt * q) >> 16);
        neg = (d[i] < 0) != (tension < 0);
        if (neg) f = -f;
        g = (i == 2) ? grav : 0;
        d[i] = sat48((f + g) / 2);
        f = sat48((g - f) / 2);
        case (i)
          0: begin o.start_force_x = d[i][47:0]; o.end_force_x = f[47:0]; end
          1: begin o.start_force_y = d[i][47:0]; o.end_force_y = f[47:0]; end
          default: begin o.start_force_z = d[i][47:0]; o.end_force_z = f[47:0]; end
        endcase
      end
      o.status = sbf_pkg::ST_ACTIVE;
      pending.push_back(o);
    endfunction

    task check_result(sbf_pkg::out_t got);
      sbf_pkg::out_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.status), 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
      if (got.start_force_x !== w.start_force_x)
        report("start_force_x", 64'(got.start_force_x), 64'(w.start_force_x));
      if (got.start_force_y !== w.start_force_y)
        report("start_force_y", 64'(got.start_force_y), 64'(w.start_force_y));
      if (got.start_force_z !== w.start_force_z)
        report("start_force_z", 64'(got.start_force_z), 64'(w.start_force_z));
      if (got.end_force_x !== w.end_force_x)
        report("end_force_x", 64'(got.end_force_x), 64'(w.end_force_x));
      if (got.end_force_y !== w.end_force_y)
        report("end_force_y", 64'(got.end_force_y), 64'(w.end_force_y));
      if (got.end_force_z !== w.end_force_z)
        report("end_force_z", 64'(got.end_force_z), 64'(w.end_force_z));
      if (got.tension_out !== w.tension_out)
        report("tension_out", 64'(got.tension_out), 64'(w.tension_out));
      if (got.length_out !== w.length_out)
        report("length_out", 64'(got.length_out), 64'(w.length_out));
    endtask
  endclass

  beam_scoreboard sb = new();

  // result side: random stall, check on every accepted result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high after a request is taken and is dropped by an idle
  // cycle or by drain, so each step has one update of in_valid
  task automatic send(input sbf_pkg::in_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(input sbf_pkg::reg_idx_t idx, input logic [46:0] val);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // fresh beam: reset-like restart is not available, so a new beam is simply
  // a new scoreboard state only after reset; phases keep one beam lifetime.
  function automatic sbf_pkg::in_t rand_pos(int span);
    sbf_pkg::in_t r;
    r.pins_present = 1'b1;
    r.start_x = $urandom_range(2*span) - span;
    r.start_y = $urandom_range(2*span) - span;
    r.start_z = $urandom_range(2*span) - span;
    r.end_x = $urandom_range(2*span) - span;
    r.end_y = $urandom_range(2*span) - span;
    r.end_z = $urandom_range(2*span) - span;
    return r;
  endfunction

  function automatic sbf_pkg::in_t rand_wide();
    sbf_pkg::in_t r;
    r = {1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  initial begin
    sbf_pkg::in_t r;
    sb.clear_beam();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: the beam lives once, so stay unbreakable until the end.
    cfg_write(sbf_pkg::REG_BREAKABLE, 47'd0);
    cfg_write(sbf_pkg::REG_STIFFNESS, 47'(32'hFFFF_FFFF));
    cfg_write(sbf_pkg::REG_BEAM_MASS, 47'(16'hFFFF));
    cfg_write(sbf_pkg::REG_RESISTANCE, 47'd0);
    r = '0; r.pins_present = 1'b1;
    send(r);                             // zero length, latches rest length
    r.end_x = 32'sh7FFF_FFFF; r.start_x = 32'sh8000_0000;
    send(r);
    r.end_y = 32'sh8000_0000; r.start_y = 32'sh7FFF_FFFF;
    r.end_z = 32'sh7FFF_FFFF; r.start_z = 32'sh8000_0000;
    send(r);
    r = '0; r.pins_present = 1'b1; r.end_z = -32'sd256;
    send(r);
    send(rand_wide());
    drain();
    cfg_write(sbf_pkg::REG_STIFFNESS, 47'd0);
    cfg_write(sbf_pkg::REG_BEAM_MASS, 47'd0);
    send(rand_wide());
    drain();
    cfg_write(sbf_pkg::REG_STIFFNESS, 47'd65536);
    cfg_write(sbf_pkg::REG_BEAM_MASS, 47'd256);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      cfg_write(sbf_pkg::REG_STIFFNESS, ($urandom_range(3) == 0) ?
                47'($urandom) : 47'($urandom_range(200000)));
      cfg_write(sbf_pkg::REG_BEAM_MASS, 47'(16'($urandom)));
      for (int k = 0; k < 145; k++) send($urandom_range(3) == 0 ? rand_wide() : rand_pos(4000));
      drain();
    end
    // breaking: enable with small resistance, then missing pin and removed beam
    cfg_write(sbf_pkg::REG_RESISTANCE, 47'd1000);
    cfg_write(sbf_pkg::REG_BREAKABLE, 47'd1);
    send(rand_wide());
    send(rand_wide());
    r = rand_wide(); r.pins_present = 1'b0;
    send(r);
    send(r);
    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
